>>> src/cst_pkg.sv
// Shared types and constants for the scheduler tick block.
package cst_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = $clog2(MAX_PROCS);
    localparam int CNT_BITS  = $clog2(MAX_PROCS + 1);
    localparam int PID_BITS  = 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]  NO_SLOT  = CNT_BITS'(MAX_PROCS);

    localparam logic [1:0] ALG_FCFS = 2'd0;
    localparam logic [1:0] ALG_SJF  = 2'd1;
    localparam logic [1:0] ALG_SRTF = 2'd2;
    localparam logic [1:0] ALG_RR   = 2'd3;

    localparam logic [1:0] REG_ALGORITHM = 2'd0;
    localparam logic [1:0] REG_QUANTUM   = 2'd1;
    localparam logic [1:0] REG_COUNT     = 2'd2;

    // per-slot record held by one cell
    typedef struct packed {
        logic [PID_BITS-1:0]  pid;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] start;
        logic                 started;
        logic                 entered;
        logic                 finished;
    } slot_rec_t;

    // ready list entry in a shift cell
    typedef struct packed {
        logic                 valid;
        logic [SLOT_BITS-1:0] slot;
    } rdy_ent_t;

endpackage

>>> src/cpu_scheduler_tick.sv
// Top level of the scheduler tick block: sequencer over slot cells and a ready chain.
//
// Channels: s_axis carries load and tick items; tdata packs slot, proc_id,
// arrival_time, burst_length and tuser holds mode. m_axis returns one result
// per tick item; a load item gives no result. cfg writes algorithm (0),
// time_quantum (1) and process_count (2) while the block is idle.
// A load walks the ready chain once to drop the slot, then writes the slot
// record. A tick walks the slots once for arrivals (one slot a cycle), the
// ready list once for the selection (one entry a cycle), takes out the
// chosen entry by shifting the chain, runs the process, then walks the
// slots again to fold the finished flags into all_done.
// The result sits in an output register; s_axis is not ready again until
// that register is taken, so a stalled receiver stalls the input. The next
// item is taken at the earliest in the cycle after the result is taken.
// Reset clears the flags of all slots, empties the ready list, sets time 0,
// quantum 4, algorithm FCFS and zero processes. Slot payloads are undefined
// until loaded.
module cpu_scheduler_tick (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // slot[3:0], proc_id, arrival_time, burst_length
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // tick_time, run_id, done_start, done_finish
    output logic [2:0]  m_axis_tuser,  // idle, done_res, all_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cst_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LDROP  = 4'd1;
    localparam logic [3:0] ST_LSHIFT = 4'd2;
    localparam logic [3:0] ST_ARR    = 4'd3;
    localparam logic [3:0] ST_SEL    = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_TAKE   = 4'd6;
    localparam logic [3:0] ST_RUN    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;
    localparam logic [3:0] ST_LWR    = 4'd9;
    localparam logic [3:0] ST_PUSH2  = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           alg_reg;
    logic [TIME_BITS-1:0] quant_reg;
    logic [CNT_BITS-1:0]  pcount_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CNT_BITS-1:0]  cur_reg;
    logic [TIME_BITS-1:0] slice_reg;
    logic [CNT_BITS-1:0]  rcount_reg;
    logic [CNT_BITS-1:0]  idx_reg;
    logic [CNT_BITS-1:0]  best_reg;
    logic [SLOT_BITS-1:0] in_slot_reg;
    logic [PID_BITS-1:0]  in_pid_reg;
    logic [TIME_BITS-1:0] in_arr_reg, in_burst_reg;
    logic                 cand_push_reg;  // SRTF: candidate preempts, current pushed back
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [2:0]           out_user_reg;

    slot_rec_t            rec [MAX_PROCS];
    logic                 slot_wr [MAX_PROCS];
    slot_rec_t            slot_wrec;
    logic [SLOT_BITS-1:0] slot_wsel;
    logic                 slot_we;

    rdy_ent_t             rent [MAX_PROCS];
    logic                 r_shift [MAX_PROCS];
    logic                 r_load [MAX_PROCS];
    logic [CNT_BITS-1:0]  rm_pos;
    logic                 rm_en;
    logic                 push_en;
    logic [SLOT_BITS-1:0] push_slot;

    logic [CNT_BITS-1:0]  count_eff;
    logic [TIME_BITS-1:0] quant_eff;
    logic [SLOT_BITS-1:0] cur_s;
    logic [SLOT_BITS-1:0] idx_s;
    logic [SLOT_BITS-1:0] best_s;
    slot_rec_t            cur_rec, idx_rec, best_rec, ent_rec;
    logic                 run_done;

    assign count_eff = (pcount_reg > NO_SLOT) ? NO_SLOT : pcount_reg;
    assign quant_eff = (quant_reg == '0) ? TIME_BITS'(1) : quant_reg;
    assign cur_s     = cur_reg[SLOT_BITS-1:0];
    assign idx_s     = idx_reg[SLOT_BITS-1:0];
    assign best_s    = rent[best_reg[SLOT_BITS-1:0]].slot;
    assign cur_rec   = rec[cur_s];
    assign idx_rec   = rec[idx_s];
    assign best_rec  = rec[best_s];
    assign ent_rec   = rec[rent[idx_s].slot];
    assign run_done  = (cur_reg != NO_SLOT) && (cur_rec.remaining <= TIME_BITS'(1));

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // slot cells
    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_slot
            assign slot_wr[g] = slot_we && (slot_wsel == SLOT_BITS'(g));
            cst_slot_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .wr_en  (slot_wr[g]),
                .wr_rec (slot_wrec),
                .rec    (rec[g])
            );
        end
    endgenerate

    // ready chain cells: removal shifts cells at and above rm_pos
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_rdy
            rdy_ent_t nbr;
            if (g == MAX_PROCS - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = rent[g+1];
            end
            assign r_shift[g] = rm_en && (CNT_BITS'(g) >= rm_pos);
            assign r_load[g]  = push_en &&
                (CNT_BITS'(g) == (rm_en ? rcount_reg - 1'b1 : rcount_reg));
            cst_ready_cell u_rc (
                .clk      (clk),
                .rst_n    (rst_n),
                .clr      (1'b0),
                .shift    (r_shift[g]),
                .nbr      (nbr),
                .load     (r_load[g]),
                .load_ent ({1'b1, push_slot}),
                .ent      (rent[g])
            );
        end
    endgenerate

    // sequencer control and cell write strobes
    always_comb
    begin
        state_next = state_reg;
        slot_we    = 1'b0;
        slot_wsel  = idx_s;
        slot_wrec  = idx_rec;
        rm_en      = 1'b0;
        rm_pos     = idx_reg;
        push_en    = 1'b0;
        push_slot  = cur_s;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    state_next = s_axis_tuser ? ST_ARR : ST_LDROP;
                end
            end
            ST_LDROP:
            begin
                if (idx_reg >= rcount_reg)
                begin
                    state_next = ST_LWR;
                end
                else if (rent[idx_s].slot == in_slot_reg)
                begin
                    rm_en      = 1'b1;
                    state_next = ST_LWR;
                end
            end
            ST_LWR:
            begin
                slot_we            = 1'b1;
                slot_wsel          = in_slot_reg;
                slot_wrec.pid      = in_pid_reg;
                slot_wrec.arrival  = in_arr_reg;
                slot_wrec.burst    = in_burst_reg;
                slot_wrec.remaining= in_burst_reg;
                slot_wrec.start    = '0;
                slot_wrec.started  = 1'b0;
                slot_wrec.entered  = 1'b0;
                slot_wrec.finished = 1'b0;
                state_next         = ST_IDLE;
            end
            ST_ARR:
            begin
                if (idx_reg >= count_eff)
                begin
                    state_next = ST_SEL;
                end
                else if (!idx_rec.entered && idx_rec.arrival == now_reg)
                begin
                    slot_we           = 1'b1;
                    slot_wrec.entered = 1'b1;
                    push_en           = (rcount_reg < NO_SLOT);
                    push_slot         = idx_s;
                end
            end
            ST_SEL:
            begin
                if (idx_reg >= rcount_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_RUN;
                if (rcount_reg != '0)
                begin
                    if (alg_reg == ALG_SRTF)
                    begin
                        state_next = ST_TAKE;
                    end
                    else if (cur_reg == NO_SLOT)
                    begin
                        state_next = ST_TAKE;
                    end
                end
            end
            ST_TAKE:
            begin
                // remove chosen entry; SRTF preempt or keep
                rm_en  = 1'b1;
                rm_pos = best_reg;
                if (cand_push_reg)
                begin
                    push_en   = 1'b1;
                    push_slot = cur_s;
                end
                else if (alg_reg == ALG_SRTF && cur_reg != NO_SLOT &&
                         !(best_rec.remaining < cur_rec.remaining))
                begin
                    push_en   = 1'b1;
                    push_slot = best_s;
                end
                state_next = ST_PUSH2;
            end
            ST_PUSH2:
            begin
                // mark start of the new running slot
                if (cur_reg != NO_SLOT && !cur_rec.started)
                begin
                    slot_we           = 1'b1;
                    slot_wsel         = cur_s;
                    slot_wrec         = cur_rec;
                    slot_wrec.started = 1'b1;
                    slot_wrec.start   = now_reg;
                end
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cur_reg != NO_SLOT)
                begin
                    slot_we   = 1'b1;
                    slot_wsel = cur_s;
                    slot_wrec = cur_rec;
                    if (cur_rec.remaining <= TIME_BITS'(1))
                    begin
                        slot_wrec.remaining = '0;
                        slot_wrec.finished  = 1'b1;
                    end
                    else
                    begin
                        slot_wrec.remaining = cur_rec.remaining - 1'b1;
                        if (alg_reg == ALG_RR && slice_reg <= TIME_BITS'(1))
                        begin
                            push_en   = (rcount_reg < NO_SLOT);
                            push_slot = cur_s;
                        end
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (idx_reg >= count_eff)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alg_reg       <= ALG_FCFS;
            quant_reg     <= TIME_BITS'(4);
            pcount_reg    <= '0;
            now_reg       <= '0;
            cur_reg       <= NO_SLOT;
            slice_reg     <= TIME_BITS'(4);
            rcount_reg    <= '0;
            idx_reg       <= '0;
            best_reg      <= '0;
            cand_push_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALGORITHM: alg_reg    <= cfg_data[1:0];
                    REG_QUANTUM:   quant_reg  <= cfg_data;
                    REG_COUNT:     pcount_reg <= cfg_data[CNT_BITS-1:0];
                    default:       ;
                endcase
            end
            // ready count follows removals and pushes
            rcount_reg <= rcount_reg - CNT_BITS'(rm_en) + CNT_BITS'(push_en);
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                end
                ST_LDROP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_LWR:
                begin
                    if (cur_reg == CNT_BITS'(in_slot_reg))
                    begin
                        cur_reg   <= NO_SLOT;
                        slice_reg <= quant_eff;
                    end
                end
                ST_ARR:
                begin
                    if (idx_reg >= count_eff)
                    begin
                        idx_reg  <= CNT_BITS'(1);
                        best_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SEL:
                begin
                    // walk the list keeping the best metric
                    if (idx_reg < rcount_reg)
                    begin
                        if (alg_reg == ALG_SJF || alg_reg == ALG_SRTF)
                        begin
                            if (((alg_reg == ALG_SRTF) ?
                                 (ent_rec.remaining < best_rec.remaining) :
                                 (ent_rec.burst < best_rec.burst)) ||
                                (((alg_reg == ALG_SRTF) ?
                                  (ent_rec.remaining == best_rec.remaining) :
                                  (ent_rec.burst == best_rec.burst)) &&
                                 ent_rec.pid < best_rec.pid))
                            begin
                                best_reg <= idx_reg;
                            end
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DECIDE:
                begin
                    cand_push_reg <= (alg_reg == ALG_SRTF) && (cur_reg != NO_SLOT) &&
                                     (best_rec.remaining < cur_rec.remaining);
                end
                ST_TAKE:
                begin
                    if (alg_reg != ALG_SRTF || cur_reg == NO_SLOT ||
                        best_rec.remaining < cur_rec.remaining)
                    begin
                        cur_reg <= CNT_BITS'(best_s);
                        if (alg_reg == ALG_RR)
                        begin
                            slice_reg <= quant_eff;
                        end
                    end
                end
                ST_RUN:
                begin
                    out_data_reg[15:0]  <= now_reg;
                    out_data_reg[31:16] <= (cur_reg != NO_SLOT) ? cur_rec.pid : '0;
                    out_data_reg[47:32] <= run_done ? cur_rec.start : '0;
                    out_data_reg[63:48] <= run_done ?
                                           ((now_reg < TIME_MAX) ? now_reg + 1'b1 : now_reg) :
                                           '0;
                    out_user_reg[0]     <= (cur_reg == NO_SLOT);
                    out_user_reg[1]     <= run_done;
                    if (cur_reg != NO_SLOT)
                    begin
                        if (run_done)
                        begin
                            cur_reg   <= NO_SLOT;
                            slice_reg <= quant_eff;
                        end
                        else if (alg_reg == ALG_RR)
                        begin
                            if (slice_reg <= TIME_BITS'(1))
                            begin
                                cur_reg   <= NO_SLOT;
                                slice_reg <= quant_eff;
                            end
                            else
                            begin
                                slice_reg <= slice_reg - 1'b1;
                            end
                        end
                    end
                    idx_reg         <= '0;
                    out_user_reg[2] <= 1'b1;
                end
                ST_OUT:
                begin
                    // fold finished flags into all_done
                    if (idx_reg < count_eff)
                    begin
                        if (!idx_rec.finished)
                        begin
                            out_user_reg[2] <= 1'b0;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        if (now_reg < TIME_MAX)
                        begin
                            now_reg <= now_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // capture the load payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_slot_reg  <= s_axis_tdata[3:0];
            in_pid_reg   <= s_axis_tdata[19:4];
            in_arr_reg   <= s_axis_tdata[35:20];
            in_burst_reg <= (s_axis_tdata[51:36] == '0) ? TIME_BITS'(1) :
                            s_axis_tdata[51:36];
        end
    end
endmodule

>>> src/cst_slot_cell.sv
// One process slot cell: holds the slot record and applies writes from the sequencer.
module cst_slot_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  cst_pkg::slot_rec_t     wr_rec,
    output cst_pkg::slot_rec_t     rec
);
    import cst_pkg::*;

    slot_rec_t rec_reg;
    logic      started_reg, entered_reg, finished_reg;

    // hold flags under reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            entered_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            started_reg  <= wr_rec.started;
            entered_reg  <= wr_rec.entered;
            finished_reg <= wr_rec.finished;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_reg <= wr_rec;
        end
    end

    always_comb
    begin
        rec          = rec_reg;
        rec.started  = started_reg;
        rec.entered  = entered_reg;
        rec.finished = finished_reg;
    end
endmodule

>>> src/cst_ready_cell.sv
// One ready list cell: part of a shift chain, takes its right neighbor on removal.
module cst_ready_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                shift,
    input  cst_pkg::rdy_ent_t   nbr,
    input  logic                load,
    input  cst_pkg::rdy_ent_t   load_ent,
    output cst_pkg::rdy_ent_t   ent
);
    import cst_pkg::*;

    rdy_ent_t ent_reg;

    // shift from the neighbor, load a push, or drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else if (clr)
        begin
            ent_reg <= '0;
        end
        else if (load)
        begin
            ent_reg <= load_ent;
        end
        else if (shift)
        begin
            ent_reg <= nbr;
        end
    end

    assign ent = ent_reg;
endmodule

>>> src/cpu_scheduler_tick_chk.sv
// Port checker for the scheduler tick block, bound to the top level.
module cpu_scheduler_tick_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        cfg_ready
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // idle never reports a run pid
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:16] == 16'd0
        && !m_axis_tuser[1])
        else $error("idle tick reports a process");

    // no input while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with pending result");

    // completion fields zero without completion
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("completion fields set without completion");

    // register writes are open whenever items are
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> cfg_ready)
        else $error("item channel ready while register channel is not");
endmodule

bind cpu_scheduler_tick cpu_scheduler_tick_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_ready     (cfg_ready)
);
